// ===== design/wwsm_pkg.sv =====
package wwsm_pkg;

	localparam int DAY_MINS        = 24 * 60;
	localparam int WEEK_MINS       = 7 * DAY_MINS;
	localparam int MAX_WINDOWS_DEF = 16;
	localparam int MOW_W           = 14;
	localparam int SPAN_W          = 17;

	localparam logic signed [SPAN_W-1:0] WEEK_S  = SPAN_W'(WEEK_MINS);
	localparam logic signed [SPAN_W-1:0] WEEK2_S = SPAN_W'(2 * WEEK_MINS);

	typedef logic [MOW_W-1:0]         mow_t;
	typedef logic signed [SPAN_W-1:0] span_t;

	typedef enum logic [1:0] {
		CM_HOLD,
		CM_ROTATE,
		CM_COMPACT,
		CM_APPEND
	} cell_mode_t;

	// control broadcast along the chain
	typedef struct packed {
		cell_mode_t mode;
		mow_t       wstart;
		mow_t       wend;
	} cell_ctrl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_QUERY,
		ST_MERGE,
		ST_COMPACT,
		ST_APPEND,
		ST_DONE
	} state_t;

	// day, hour and minute to minute-of-week; the raw sum stays below two weeks
	function automatic mow_t to_mow(logic [2:0] day, logic [4:0] hour, logic [5:0] mins);
		logic [14:0] sum;
		sum = 15'(day) * 15'(DAY_MINS) + 15'(hour) * 15'd60 + 15'(mins);
		if (sum >= 15'(WEEK_MINS))
			sum = sum - 15'(WEEK_MINS);
		return sum[MOW_W-1:0];
	endfunction

	// reduce a span bound, known to lie in minus one to three weeks
	function automatic mow_t week_mod(span_t v);
		span_t r;
		r = v;
		if (r < 0)
			r = r + WEEK_S;
		else if (r >= WEEK2_S)
			r = r - WEEK2_S;
		else if (r >= WEEK_S)
			r = r - WEEK_S;
		return r[MOW_W-1:0];
	endfunction

endpackage

// ===== design/wwsm_cell.sv =====
module wwsm_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  wwsm_pkg::cell_ctrl_t ctrl,
	input  wwsm_pkg::mow_t       nxt_start,
	input  wwsm_pkg::mow_t       nxt_end,
	input  logic                 nxt_valid,
	input  logic                 hole_in,
	input  logic                 prev_valid,
	output wwsm_pkg::mow_t       wstart,
	output wwsm_pkg::mow_t       wend,
	output logic                 valid,
	output logic                 hole_out
);

	wwsm_pkg::mow_t start_q, end_q;
	logic           valid_q;
	logic           take_nxt;
	logic           take_new;

	// a cell at or after the first hole moves one place toward the head
	assign hole_out = hole_in | ~valid_q;

	always_comb begin
		take_nxt = 1'b0;
		take_new = 1'b0;
		case (ctrl.mode)
			wwsm_pkg::CM_ROTATE:  take_nxt = 1'b1;
			wwsm_pkg::CM_COMPACT: take_nxt = hole_out;
			wwsm_pkg::CM_APPEND:  take_new = ~valid_q & prev_valid;
			default:              ;
		endcase
	end

	// hold the validity flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (take_nxt)
			valid_q <= nxt_valid;
		else if (take_new)
			valid_q <= 1'b1;
	end

	// hold the window bounds
	always_ff @(posedge clk) begin
		if (take_nxt) begin
			start_q <= nxt_start;
			end_q   <= nxt_end;
		end else if (take_new) begin
			start_q <= ctrl.wstart;
			end_q   <= ctrl.wend;
		end
	end

	assign wstart = start_q;
	assign wend   = end_q;
	assign valid  = valid_q;

endmodule

// ===== design/wwsm_absorb.sv =====
module wwsm_absorb (
	input  wwsm_pkg::span_t ns,
	input  wwsm_pkg::span_t ne,
	input  wwsm_pkg::mow_t  es0,
	input  wwsm_pkg::mow_t  ee0,
	input  logic            valid,
	output logic            hit,
	output wwsm_pkg::span_t ns_new,
	output wwsm_pkg::span_t ne_new
);

	wwsm_pkg::span_t s0, e0;
	wwsm_pkg::span_t es [3];
	wwsm_pkg::span_t ee [3];
	logic [2:0]      fit;
	wwsm_pkg::span_t es_sel, ee_sel;

	// unwrap the stored window, then try it one week early, in place and one late
	always_comb begin
		s0 = wwsm_pkg::SPAN_W'(es0);
		e0 = wwsm_pkg::SPAN_W'(ee0);
		if (e0 < s0)
			e0 = e0 + wwsm_pkg::WEEK_S;
		es[0] = s0 - wwsm_pkg::WEEK_S;
		ee[0] = e0 - wwsm_pkg::WEEK_S;
		es[1] = s0;
		ee[1] = e0;
		es[2] = s0 + wwsm_pkg::WEEK_S;
		ee[2] = e0 + wwsm_pkg::WEEK_S;
		for (int k = 0; k < 3; k++)
			fit[k] = (es[k] <= ne + 1) && (ee[k] >= ns - 1);
		if (fit[0]) begin
			es_sel = es[0];
			ee_sel = ee[0];
		end else if (fit[1]) begin
			es_sel = es[1];
			ee_sel = ee[1];
		end else begin
			es_sel = es[2];
			ee_sel = ee[2];
		end
		hit    = valid & (|fit);
		ns_new = (hit && es_sel < ns) ? es_sel : ns;
		ne_new = (hit && ee_sel > ne) ? ee_sel : ne;
	end

endmodule

// ===== design/weekly_window_set_merge_core.sv =====
// Weekly window table: up to MAX_WINDOWS windows held in a chain of cells,
// each cell one entry, the chain rotating one place a cycle past a single
// compare unit at its head. Requests are taken one at a time: in_stall is high
// from the accepting edge until the block is idle again. A query makes one
// rotation of the chain, then a result state and an idle state. An add makes
// merge passes, one rotation each, until one absorbs nothing (at most the
// entry count plus one passes), then a compaction rotation only when
// something was absorbed, an append step unless the add is dropped as full,
// then a result state and an idle state. The result state lasts longer while
// the output register holds a word that the receiver is stalling.
module weekly_window_set_merge_core #(
	parameter int MAX_WINDOWS = wwsm_pkg::MAX_WINDOWS_DEF,
	localparam int CNT_W = $clog2(MAX_WINDOWS + 1),
	localparam int IDX_W = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             req_type,
	input  logic [2:0]       first_day,
	input  logic [4:0]       start_hour,
	input  logic [5:0]       start_min,
	input  logic [2:0]       end_day,
	input  logic [4:0]       end_hour,
	input  logic [5:0]       end_min,
	input  logic [2:0]       query_day,
	input  logic [4:0]       query_hour,
	input  logic [5:0]       query_min,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             active,
	output logic [CNT_W-1:0] window_count,
	output logic             table_full
);

	wwsm_pkg::state_t     state_q, state_d;
	wwsm_pkg::cell_ctrl_t ctrl;
	wwsm_pkg::mow_t       c_start [MAX_WINDOWS];
	wwsm_pkg::mow_t       c_end   [MAX_WINDOWS];
	logic                 c_valid [MAX_WINDOWS];
	logic                 c_hole  [MAX_WINDOWS];
	wwsm_pkg::mow_t       tail_start, tail_end;
	logic                 tail_valid;

	logic [IDX_W-1:0]     cnt_q;
	logic [CNT_W-1:0]     count_q;
	wwsm_pkg::span_t      ns_q, ne_q;
	wwsm_pkg::mow_t       qm_q;
	logic                 hit_q, changed_q, any_q, full_q;
	logic                 last_step;
	logic                 absorb_hit;
	wwsm_pkg::span_t      ns_new, ne_new;
	logic                 q_hit;
	wwsm_pkg::mow_t       ins_start, ins_end;
	logic                 ld_out;
	logic                 out_valid_q, active_q, full_out_q;
	logic [CNT_W-1:0]     count_out_q;
	wwsm_pkg::mow_t       mow_s, mow_e;
	wwsm_pkg::span_t      ne_in;

	assign last_step = (cnt_q == IDX_W'(MAX_WINDOWS - 1));

	// the chain of entries
	for (genvar i = 0; i < MAX_WINDOWS; i++) begin : g_cell
		wwsm_pkg::mow_t nstart, nend;
		logic           nvalid;
		if (i == MAX_WINDOWS - 1) begin : g_tail
			assign nstart = tail_start;
			assign nend   = tail_end;
			assign nvalid = tail_valid;
		end else begin : g_mid
			assign nstart = c_start[i+1];
			assign nend   = c_end[i+1];
			assign nvalid = c_valid[i+1];
		end
		wwsm_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.nxt_start  (nstart),
			.nxt_end    (nend),
			.nxt_valid  (nvalid),
			.hole_in    ((i == 0) ? 1'b0 : c_hole[(i == 0) ? 0 : i-1]),
			.prev_valid ((i == 0) ? 1'b1 : c_valid[(i == 0) ? 0 : i-1]),
			.wstart     (c_start[i]),
			.wend       (c_end[i]),
			.valid      (c_valid[i]),
			.hole_out   (c_hole[i])
		);
	end

	// compare unit at the head of the chain
	wwsm_absorb u_absorb (
		.ns     (ns_q),
		.ne     (ne_q),
		.es0    (c_start[0]),
		.ee0    (c_end[0]),
		.valid  (c_valid[0] && state_q == wwsm_pkg::ST_MERGE),
		.hit    (absorb_hit),
		.ns_new (ns_new),
		.ne_new (ne_new)
	);

	// query test on the head entry, wrapping where start is after end
	always_comb begin
		if (c_start[0] <= c_end[0])
			q_hit = qm_q >= c_start[0] && qm_q <= c_end[0];
		else
			q_hit = qm_q >= c_start[0] || qm_q <= c_end[0];
		q_hit = q_hit & c_valid[0];
	end

	// recirculate the head, dropping an absorbed entry
	assign tail_start = c_start[0];
	assign tail_end   = c_end[0];
	assign tail_valid = (state_q == wwsm_pkg::ST_COMPACT) ? 1'b0 : (c_valid[0] & ~absorb_hit);

	// merged window to store: whole week, or both ends folded into the week
	always_comb begin
		if (ne_q - ns_q + 1 >= wwsm_pkg::WEEK_S) begin
			ins_start = '0;
			ins_end   = wwsm_pkg::MOW_W'(wwsm_pkg::WEEK_MINS - 1);
		end else begin
			ins_start = wwsm_pkg::week_mod(ns_q);
			ins_end   = wwsm_pkg::week_mod(ne_q);
		end
	end

	assign mow_s = wwsm_pkg::to_mow(first_day, start_hour, start_min);
	assign mow_e = wwsm_pkg::to_mow(end_day, end_hour, end_min);
	assign ne_in = (mow_e < mow_s) ? wwsm_pkg::SPAN_W'(mow_e) + wwsm_pkg::WEEK_S
		: wwsm_pkg::SPAN_W'(mow_e);

	assign ld_out   = (state_q == wwsm_pkg::ST_DONE) && (!out_valid_q || !out_stall);
	assign in_stall = (state_q != wwsm_pkg::ST_IDLE);

	// next state and chain control
	always_comb begin
		state_d     = state_q;
		ctrl.mode   = wwsm_pkg::CM_HOLD;
		ctrl.wstart = ins_start;
		ctrl.wend   = ins_end;
		unique case (state_q)
			wwsm_pkg::ST_IDLE: begin
				if (in_valid)
					state_d = req_type ? wwsm_pkg::ST_QUERY : wwsm_pkg::ST_MERGE;
			end
			wwsm_pkg::ST_QUERY: begin
				ctrl.mode = wwsm_pkg::CM_ROTATE;
				if (last_step)
					state_d = wwsm_pkg::ST_DONE;
			end
			wwsm_pkg::ST_MERGE: begin
				ctrl.mode = wwsm_pkg::CM_ROTATE;
				if (last_step && !(changed_q || absorb_hit)) begin
					if (!(any_q || absorb_hit) && count_q >= CNT_W'(MAX_WINDOWS))
						state_d = wwsm_pkg::ST_DONE;
					else if (any_q || absorb_hit)
						state_d = wwsm_pkg::ST_COMPACT;
					else
						state_d = wwsm_pkg::ST_APPEND;
				end
			end
			wwsm_pkg::ST_COMPACT: begin
				ctrl.mode = wwsm_pkg::CM_COMPACT;
				if (last_step)
					state_d = wwsm_pkg::ST_APPEND;
			end
			wwsm_pkg::ST_APPEND: begin
				ctrl.mode = wwsm_pkg::CM_APPEND;
				state_d   = wwsm_pkg::ST_DONE;
			end
			wwsm_pkg::ST_DONE: begin
				if (ld_out)
					state_d = wwsm_pkg::ST_IDLE;
			end
			default: state_d = wwsm_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= wwsm_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	// step counter, flags and stored count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			count_q   <= '0;
			hit_q     <= 1'b0;
			changed_q <= 1'b0;
			any_q     <= 1'b0;
			full_q    <= 1'b0;
		end else begin
			if (state_q == wwsm_pkg::ST_QUERY || state_q == wwsm_pkg::ST_MERGE
				|| state_q == wwsm_pkg::ST_COMPACT)
				cnt_q <= last_step ? '0 : cnt_q + 1'b1;
			else
				cnt_q <= '0;
			case (state_q)
				wwsm_pkg::ST_IDLE: begin
					hit_q     <= 1'b0;
					changed_q <= 1'b0;
					any_q     <= 1'b0;
					full_q    <= 1'b0;
				end
				wwsm_pkg::ST_QUERY: begin
					if (q_hit)
						hit_q <= 1'b1;
				end
				wwsm_pkg::ST_MERGE: begin
					if (absorb_hit) begin
						any_q   <= 1'b1;
						count_q <= count_q - 1'b1;
					end
					if (last_step)
						changed_q <= 1'b0;
					else if (absorb_hit)
						changed_q <= 1'b1;
					if (last_step && !(changed_q || absorb_hit) && !(any_q || absorb_hit)
						&& count_q >= CNT_W'(MAX_WINDOWS))
						full_q <= 1'b1;
				end
				wwsm_pkg::ST_APPEND: count_q <= count_q + 1'b1;
				default: ;
			endcase
		end
	end

	// capture the request and track the growing span
	always_ff @(posedge clk) begin
		if (state_q == wwsm_pkg::ST_IDLE && in_valid) begin
			qm_q <= wwsm_pkg::to_mow(query_day, query_hour, query_min);
			ns_q <= wwsm_pkg::SPAN_W'(mow_s);
			ne_q <= ne_in;
		end else if (state_q == wwsm_pkg::ST_MERGE) begin
			ns_q <= ns_new;
			ne_q <= ne_new;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (ld_out)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (ld_out) begin
			active_q    <= hit_q;
			full_out_q  <= full_q;
			count_out_q <= count_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign active       = active_q;
	assign table_full   = full_out_q;
	assign window_count = count_out_q;

endmodule
